### rtl/pffe_pkg.sv
package pffe_pkg;

    // largest message length the hardware can ever accept
    localparam int unsigned MAX_FRAME_LIMIT = 65536;
    localparam int unsigned FRAME_W         = $clog2(MAX_FRAME_LIMIT + 1);

    // configuration port
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 29;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_FRAME_LEN   = 2'd0,
        CFG_MAX_PAYLOAD_LEN = 2'd1,
        CFG_TARGET_FIELD    = 2'd2
    } t_cfg_idx;

    localparam logic [16:0] MAX_FRAME_LEN_RST   = 17'd65536;
    localparam logic [15:0] MAX_PAYLOAD_LEN_RST = 16'd4094;
    localparam logic [28:0] TARGET_FIELD_RST    = 29'd6;

    // protobuf wire format
    localparam logic [2:0] WT_VARINT     = 3'd0;
    localparam logic [2:0] WT_LEN_DELIM  = 3'd2;
    localparam logic [3:0] VARINT_LAST   = 4'd9;
    localparam logic [6:0] VARINT_DIGIT  = 7'd7;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_OVERSIZE  = 2'd2
    } t_status;

    typedef struct packed {
        logic [16:0] max_frame_len;
        logic [15:0] max_payload_len;
        logic [28:0] target_field;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        byte_valid;
        logic        payload_start;
        logic [15:0] payload_len;
        logic        frame_done;
        t_status     frame_status;
    } t_result;

endpackage

### rtl/pffe_if.sv
// input byte channel
interface pffe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// result channel
interface pffe_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  payload_byte;
    logic        byte_valid;
    logic        payload_start;
    logic [15:0] payload_len;
    logic        frame_done;
    logic [1:0]  frame_status;

    modport source (output valid, output payload_byte, output byte_valid,
                    output payload_start, output payload_len, output frame_done,
                    output frame_status, input ready);
    modport sink   (input valid, input payload_byte, input byte_valid,
                    input payload_start, input payload_len, input frame_done,
                    input frame_status, output ready);
endinterface

### rtl/pffe_parser.sv
module pffe_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_byte,
    input  pffe_pkg::t_cfg    i_cfg,
    output pffe_pkg::t_result o_res,
    output logic              o_res_valid
);

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_TAG    = 3'd1,
        PH_VALUE  = 3'd2,
        PH_LENGTH = 3'd3,
        PH_RUN    = 3'd4,
        PH_DRAIN  = 3'd5
    } t_phase;

    localparam int unsigned FW = pffe_pkg::FRAME_W;

    t_phase          r_phase,     n_phase;
    logic [1:0]      r_hdr_cnt,   n_hdr_cnt;
    logic [23:0]     r_hdr,       n_hdr;
    logic [FW-1:0]   r_frame_rem, n_frame_rem;
    logic [31:0]     r_acc_lo,    n_acc_lo;
    logic            r_acc_hi,    n_acc_hi;
    logic [3:0]      r_vbytes,    n_vbytes;
    logic            r_match,     n_match;
    logic [FW-1:0]   r_run,       n_run;
    logic            r_copy,      n_copy;
    logic            r_err,       n_err;

    logic [31:0]     hdr_full;
    logic [31:0]     limit;
    logic [FW-1:0]   rem_dec;
    logic [6:0]      sh_amt;
    logic [63:0]     digit;
    logic [31:0]     val_lo;
    logic            val_hi;
    logic            fault;
    pffe_pkg::t_result res;

    // header word, effective limit and varint digit placement
    assign hdr_full = {r_hdr, i_byte};
    assign limit    = (32'(i_cfg.max_frame_len) > 32'(pffe_pkg::MAX_FRAME_LIMIT))
                    ? 32'(pffe_pkg::MAX_FRAME_LIMIT) : 32'(i_cfg.max_frame_len);
    assign rem_dec  = r_frame_rem - FW'(1);
    assign sh_amt   = 7'(r_vbytes) * pffe_pkg::VARINT_DIGIT;
    assign digit    = 64'(i_byte[6:0]) << sh_amt;
    assign val_lo   = r_acc_lo | digit[31:0];
    assign val_hi   = r_acc_hi | (|digit[63:32]);

    // next state and result for one accepted beat
    always_comb begin
        n_phase     = r_phase;
        n_hdr_cnt   = r_hdr_cnt;
        n_hdr       = r_hdr;
        n_frame_rem = r_frame_rem;
        n_acc_lo    = r_acc_lo;
        n_acc_hi    = r_acc_hi;
        n_vbytes    = r_vbytes;
        n_match     = r_match;
        n_run       = r_run;
        n_copy      = r_copy;
        n_err       = r_err;
        fault       = 1'b0;
        res         = '0;

        if (i_accept) begin
            unique case (r_phase)
                PH_HEADER: begin
                    n_hdr = hdr_full[23:0];
                    if (r_hdr_cnt == 2'd3) begin
                        n_hdr_cnt = 2'd0;
                        if (hdr_full > limit) begin
                            res.frame_done   = 1'b1;
                            res.frame_status = pffe_pkg::ST_OVERSIZE;
                        end else if (hdr_full == 32'd0) begin
                            res.frame_done   = 1'b1;
                        end else begin
                            n_phase     = PH_TAG;
                            n_frame_rem = FW'(hdr_full);
                            n_acc_lo    = '0;
                            n_acc_hi    = 1'b0;
                            n_vbytes    = '0;
                        end
                    end else begin
                        n_hdr_cnt = r_hdr_cnt + 2'd1;
                    end
                end
                PH_TAG, PH_VALUE, PH_LENGTH: begin
                    n_frame_rem = rem_dec;
                    n_acc_lo    = val_lo;
                    n_acc_hi    = val_hi;
                    if (i_byte[7]) begin
                        if (r_vbytes >= pffe_pkg::VARINT_LAST) begin
                            fault = 1'b1;
                        end else begin
                            n_vbytes = r_vbytes + 4'd1;
                        end
                    end else begin
                        n_acc_lo = '0;
                        n_acc_hi = 1'b0;
                        n_vbytes = '0;
                        if (r_phase == PH_TAG) begin
                            // wire type decides what follows the tag
                            if (val_lo[2:0] == pffe_pkg::WT_VARINT) begin
                                n_phase = PH_VALUE;
                            end else if (val_lo[2:0] == pffe_pkg::WT_LEN_DELIM) begin
                                n_match = !val_hi && (val_lo[31:3] == i_cfg.target_field);
                                n_phase = PH_LENGTH;
                            end else begin
                                fault = 1'b1;
                            end
                        end else if (r_phase == PH_VALUE) begin
                            n_phase = PH_TAG;
                        end else if (val_hi || (val_lo > 32'(rem_dec))) begin
                            // field runs past the end of the frame
                            fault = 1'b1;
                        end else begin
                            n_copy = r_match && (val_lo <= 32'(i_cfg.max_payload_len));
                            if (n_copy) begin
                                res.payload_start = 1'b1;
                                res.payload_len   = val_lo[15:0];
                            end
                            n_match = 1'b0;
                            if (val_lo == 32'd0) begin
                                n_copy  = 1'b0;
                                n_phase = PH_TAG;
                            end else begin
                                n_run   = FW'(val_lo);
                                n_phase = PH_RUN;
                            end
                        end
                    end
                end
                PH_RUN: begin
                    n_frame_rem = rem_dec;
                    if (r_copy) begin
                        res.byte_valid   = 1'b1;
                        res.payload_byte = i_byte;
                    end
                    n_run = r_run - FW'(1);
                    if (r_run == FW'(1)) begin
                        n_copy  = 1'b0;
                        n_phase = PH_TAG;
                    end
                end
                PH_DRAIN: begin
                    n_frame_rem = rem_dec;
                end
                default: begin
                    n_phase = PH_HEADER;
                end
            endcase

            // malformed input drains the rest of the frame
            if (fault) begin
                n_err    = 1'b1;
                n_phase  = PH_DRAIN;
                n_acc_lo = '0;
                n_acc_hi = 1'b0;
                n_vbytes = '0;
                n_copy   = 1'b0;
                n_match  = 1'b0;
            end

            // end of message
            if (r_phase != PH_HEADER && rem_dec == '0) begin
                res.frame_done   = 1'b1;
                res.frame_status = (n_err || n_phase != PH_TAG || n_vbytes != 4'd0)
                                 ? pffe_pkg::ST_MALFORMED : pffe_pkg::ST_OK;
            end

            // any frame end returns to the header
            if (res.frame_done) begin
                n_phase     = PH_HEADER;
                n_hdr_cnt   = 2'd0;
                n_frame_rem = '0;
                n_acc_lo    = '0;
                n_acc_hi    = 1'b0;
                n_vbytes    = '0;
                n_match     = 1'b0;
                n_run       = '0;
                n_copy      = 1'b0;
                n_err       = 1'b0;
            end
        end
    end

    assign o_res       = res;
    assign o_res_valid = res.byte_valid | res.payload_start | res.frame_done;

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_hdr_cnt   <= 2'd0;
            r_frame_rem <= '0;
            r_acc_lo    <= '0;
            r_acc_hi    <= 1'b0;
            r_vbytes    <= '0;
            r_match     <= 1'b0;
            r_run       <= '0;
            r_copy      <= 1'b0;
            r_err       <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_hdr_cnt   <= n_hdr_cnt;
            r_frame_rem <= n_frame_rem;
            r_acc_lo    <= n_acc_lo;
            r_acc_hi    <= n_acc_hi;
            r_vbytes    <= n_vbytes;
            r_match     <= n_match;
            r_run       <= n_run;
            r_copy      <= n_copy;
            r_err       <= n_err;
        end
    end

    // header bytes shift in; r_hdr keeps only the last three, so older contents are pushed out
    always_ff @(posedge i_clk) begin
        r_hdr <= n_hdr;
    end

endmodule

### rtl/protobuf_frame_field_extractor.sv
// result beats go to the output register, or to the skid register while output stalls
// one input byte per cycle while the skid slot is empty; parsing is combinational
// an output register plus a skid register keep input ready while one result waits
// reset (synchronous, active low): parser back to the header, output empty,
// registers to max_frame_len 65536, max_payload_len 4094, target_field 6
module protobuf_frame_field_extractor (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    pffe_in_if.sink                           i_rx,
    pffe_out_if.source                        o_res,
    input  logic                              i_cfg_we,
    input  logic [pffe_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pffe_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    pffe_pkg::t_cfg    r_cfg;
    pffe_pkg::t_result r_out,   r_skid;
    logic              r_out_v, r_skid_v;
    pffe_pkg::t_result res;
    logic              res_valid;
    logic              accept;
    logic              out_free;
    logic              have_res;

    assign i_rx.ready = !r_skid_v;
    assign accept     = i_rx.valid & !r_skid_v;
    assign out_free   = !r_out_v | o_res.ready;
    assign have_res   = accept & res_valid;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_frame_len   <= pffe_pkg::MAX_FRAME_LEN_RST;
            r_cfg.max_payload_len <= pffe_pkg::MAX_PAYLOAD_LEN_RST;
            r_cfg.target_field    <= pffe_pkg::TARGET_FIELD_RST;
        end else if (i_cfg_we) begin
            unique case (pffe_pkg::t_cfg_idx'(i_cfg_idx))
                pffe_pkg::CFG_MAX_FRAME_LEN:   r_cfg.max_frame_len   <= i_cfg_data[16:0];
                pffe_pkg::CFG_MAX_PAYLOAD_LEN: r_cfg.max_payload_len <= i_cfg_data[15:0];
                pffe_pkg::CFG_TARGET_FIELD:    r_cfg.target_field    <= i_cfg_data[28:0];
                default: begin
                end
            endcase
        end
    end

    pffe_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_byte      (i_rx.rx_byte),
        .i_cfg       (r_cfg),
        .o_res       (res),
        .o_res_valid (res_valid)
    );

    // output register and skid slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (out_free) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= have_res;
            end else begin
                r_out_v  <= have_res;
            end
        end else if (have_res) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_v) begin
                r_out  <= r_skid;
                r_skid <= res;
            end else begin
                r_out  <= res;
            end
        end else if (have_res) begin
            r_skid <= res;
        end
    end

    // result beat
    assign o_res.valid         = r_out_v;
    assign o_res.payload_byte  = r_out.payload_byte;
    assign o_res.byte_valid    = r_out.byte_valid;
    assign o_res.payload_start = r_out.payload_start;
    assign o_res.payload_len   = r_out.payload_len;
    assign o_res.frame_done    = r_out.frame_done;
    assign o_res.frame_status  = r_out.frame_status;

endmodule

### dv/tb.sv
`timescale 1ns / 100ps

module tb;

    // parser phases tracked by the predictor
    typedef enum logic [2:0] {
        P_HDR,
        P_TAG,
        P_SKIPVAL,
        P_LEN,
        P_BODY,
        P_DRAIN
    } t_phase;

    typedef logic [7:0] t_bytes [$];

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [pffe_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [pffe_pkg::CFG_DATA_W-1:0] cfg_data;

    pffe_in_if  rx ();
    pffe_out_if res ();

    protobuf_frame_field_extractor dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_rx       (rx),
        .o_res      (res),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    pffe_pkg::t_result due_results [$];
    int unsigned n_fail        = 0;
    int unsigned src_idle_pct  = 0;
    int unsigned dst_stall_pct = 0;
    int unsigned hold_cycles   = 0;
    int unsigned hold_seq      = 0;
    int unsigned bytes_sent    = 0;

    // predictor copy of the registers
    logic [16:0] lim_frame;
    logic [15:0] lim_payload;
    logic [28:0] want_field;

    // predictor parse state
    t_phase      phase;
    logic [1:0]  hdr_cnt;
    logic [31:0] frame_left;
    logic [63:0] vint_acc;
    logic [3:0]  vint_cnt;
    logic        tag_hit;
    logic [63:0] body_left;
    logic        body_copy;
    logic        frame_bad;

    // clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // frame parser predictor
    // ------------------------------------------------------------------

    function automatic void clear_parser();
        phase      = P_HDR;
        hdr_cnt    = '0;
        frame_left = '0;
        vint_acc   = '0;
        vint_cnt   = '0;
        tag_hit    = 1'b0;
        body_left  = '0;
        body_copy  = 1'b0;
        frame_bad  = 1'b0;
    endfunction

    // effective message length limit, clamped to what the hardware supports
    function automatic int unsigned frame_cap();
        return (lim_frame > pffe_pkg::MAX_FRAME_LIMIT) ? pffe_pkg::MAX_FRAME_LIMIT
                                                      : int'(lim_frame);
    endfunction

    // advance the parser by one byte; returns 1 when the byte gives a result beat
    function automatic bit parse_byte(input logic [7:0] b, output pffe_pkg::t_result r);
        logic [63:0] val;
        logic [63:0] digit;
        logic        fault;
        r     = '0;
        fault = 1'b0;
        if (phase == P_HDR) begin
            frame_left = {frame_left[23:0], b};
            if (hdr_cnt == 2'd3) begin
                hdr_cnt = 2'd0;
                if (frame_left > frame_cap()) begin
                    r.frame_done   = 1'b1;
                    r.frame_status = pffe_pkg::ST_OVERSIZE;
                    clear_parser();
                end else if (frame_left == 0) begin
                    r.frame_done = 1'b1;
                    clear_parser();
                end else begin
                    phase    = P_TAG;
                    vint_acc = '0;
                    vint_cnt = '0;
                end
            end else begin
                hdr_cnt = hdr_cnt + 2'd1;
            end
        end else begin
            frame_left = frame_left - 32'd1;
            if (phase == P_TAG || phase == P_SKIPVAL || phase == P_LEN) begin
                // varint digit; bits beyond 64 fall off the shift
                digit    = {57'd0, b[6:0]};
                vint_acc = vint_acc | (digit << (7 * vint_cnt));
                if (b[7]) begin
                    if (vint_cnt >= 4'd9) begin
                        fault = 1'b1;
                    end else begin
                        vint_cnt = vint_cnt + 4'd1;
                    end
                end else begin
                    val      = vint_acc;
                    vint_acc = '0;
                    vint_cnt = '0;
                    if (phase == P_TAG) begin
                        if (val[2:0] == pffe_pkg::WT_VARINT) begin
                            phase = P_SKIPVAL;
                        end else if (val[2:0] == pffe_pkg::WT_LEN_DELIM) begin
                            tag_hit = ((val >> 3) == {35'd0, want_field});
                            phase   = P_LEN;
                        end else begin
                            fault = 1'b1;
                        end
                    end else if (phase == P_SKIPVAL) begin
                        phase = P_TAG;
                    end else if (val > {32'd0, frame_left}) begin
                        fault = 1'b1;
                    end else begin
                        body_copy = tag_hit && (val <= {48'd0, lim_payload});
                        if (body_copy) begin
                            r.payload_start = 1'b1;
                            r.payload_len   = val[15:0];
                        end
                        tag_hit = 1'b0;
                        if (val == 0) begin
                            body_copy = 1'b0;
                            phase     = P_TAG;
                        end else begin
                            body_left = val;
                            phase     = P_BODY;
                        end
                    end
                end
            end else if (phase == P_BODY) begin
                if (body_copy) begin
                    r.byte_valid   = 1'b1;
                    r.payload_byte = b;
                end
                body_left = body_left - 64'd1;
                if (body_left == 0) begin
                    body_copy = 1'b0;
                    phase     = P_TAG;
                end
            end
            // malformed: drain the rest of the frame
            if (fault) begin
                frame_bad = 1'b1;
                phase     = P_DRAIN;
                vint_acc  = '0;
                vint_cnt  = '0;
                body_copy = 1'b0;
                tag_hit   = 1'b0;
            end
            if (frame_left == 0) begin
                r.frame_done   = 1'b1;
                r.frame_status = (frame_bad || phase != P_TAG || vint_cnt != 0) ?
                                 pffe_pkg::ST_MALFORMED : pffe_pkg::ST_OK;
                clear_parser();
            end
        end
        return r.byte_valid || r.payload_start || r.frame_done;
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // offer one byte, with random idle cycles ahead of it, and wait for the beat
    task automatic send_byte(input logic [7:0] b);
        pffe_pkg::t_result r;
        while ($urandom_range(99) < src_idle_pct) begin
            rx.valid <= 1'b0;
            @(posedge clk);
        end
        if (parse_byte(b, r)) due_results.push_back(r);
        rx.valid   <= 1'b1;
        rx.rx_byte <= b;
        @(posedge clk);
        while (!rx.ready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_stream(input t_bytes seq);
        foreach (seq[i]) send_byte(seq[i]);
    endtask

    // 4-byte big-endian message length
    task automatic send_header(input logic [31:0] len);
        send_byte(len[31:24]);
        send_byte(len[23:16]);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
    endtask

    // sender goes quiet until every expected beat has come out
    task automatic wait_drained();
        rx.valid <= 1'b0;
        while (due_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_limits(input logic [16:0] frame_lim, input logic [15:0] pay_lim,
                                  input logic [28:0] field);
        cfg_we   <= 1'b1;
        cfg_idx  <= pffe_pkg::CFG_MAX_FRAME_LEN;
        cfg_data <= {12'd0, frame_lim};
        @(posedge clk);
        cfg_idx  <= pffe_pkg::CFG_MAX_PAYLOAD_LEN;
        cfg_data <= {13'd0, pay_lim};
        @(posedge clk);
        cfg_idx  <= pffe_pkg::CFG_TARGET_FIELD;
        cfg_data <= field;
        @(posedge clk);
        cfg_we      <= 1'b0;
        lim_frame   = frame_lim;
        lim_payload = pay_lim;
        want_field  = field;
    endtask

    // ------------------------------------------------------------------
    // frame builders
    // ------------------------------------------------------------------

    // varint with optional redundant continuation bytes; junk lands in the
    // bits of a tenth byte that lie beyond bit 63
    task automatic put_varint(ref t_bytes q, input logic [63:0] value, input int pad,
                              input bit junk);
        int          n;
        int          i;
        logic [63:0] rest;
        logic [7:0]  b;
        n    = 1;
        rest = value >> 7;
        while (rest != 0) begin
            n++;
            rest = rest >> 7;
        end
        n = n + pad;
        if (n > 10) n = 10;
        for (i = 0; i < n; i++) begin
            b = {1'b0, 7'(value >> (7 * i))};
            if (i < n - 1) begin
                b[7] = 1'b1;
            end else if (i == 9 && junk) begin
                b[6:1] = 6'($urandom);
            end
            q.push_back(b);
        end
    endtask

    function automatic int rand_pad();
        return ($urandom_range(9) == 0) ? $urandom_range(3, 1) : 0;
    endfunction

    function automatic logic [63:0] rand_wide();
        logic [63:0] v;
        int          w;
        v = {$urandom, $urandom};
        w = $urandom_range(64, 1);
        if (w < 64) v = v & ((64'd1 << w) - 64'd1);
        return v;
    endfunction

    // field length near the payload limit when that limit is small
    function automatic int pick_len();
        int sel;
        sel = $urandom_range(19);
        if (lim_payload <= 16'd40 && sel < 3) return int'(lim_payload);
        if (lim_payload <= 16'd39 && sel < 6) return int'(lim_payload) + 1;
        return $urandom_range(12);
    endfunction

    task automatic put_extract_field(ref t_bytes q, input int len);
        put_varint(q, ({35'd0, want_field} << 3) | pffe_pkg::WT_LEN_DELIM, rand_pad(), 1'b0);
        put_varint(q, 64'(len), rand_pad(), 1'b0);
        repeat (len) q.push_back(8'($urandom));
    endtask

    // well-formed fields: skipped varints, target fields, other delimited fields
    task automatic put_fields(ref t_bytes q, input int n_fields);
        int          sel;
        int          len;
        logic [63:0] fnum;
        repeat (n_fields) begin
            sel = $urandom_range(99);
            if (sel < 30) begin
                fnum = ($urandom_range(3) == 0) ? {35'd0, want_field} : {35'd0, 29'($urandom)};
                put_varint(q, (fnum << 3) | pffe_pkg::WT_VARINT, rand_pad(), 1'b0);
                put_varint(q, rand_wide(), rand_pad(), 1'b1);
            end else if (sel < 85) begin
                put_extract_field(q, pick_len());
            end else begin
                fnum = $urandom_range(1) ? {35'd0, 29'($urandom)} : ({$urandom, $urandom} >> 3);
                if (fnum == {35'd0, want_field}) fnum = fnum + 64'd1;
                put_varint(q, (fnum << 3) | pffe_pkg::WT_LEN_DELIM, rand_pad(), 1'b0);
                len = $urandom_range(8);
                put_varint(q, 64'(len), 0, 1'b0);
                repeat (len) q.push_back(8'($urandom));
            end
        end
    endtask

    task automatic send_random_frame();
        t_bytes      msg;
        logic [31:0] hdr;
        logic [2:0]  wt;
        int          sel;
        int          cut;
        int          tail;
        sel = $urandom_range(99);
        if (sel < 55) begin
            put_fields(msg, $urandom_range(4, 1));
        end else if (sel < 65) begin
            // message cut short, possibly inside a varint or right after a tag
            put_fields(msg, $urandom_range(3, 1));
            cut = $urandom_range(msg.size() - 1, 1);
            msg = msg[0:cut-1];
        end else if (sel < 73) begin
            // unknown wire type
            if ($urandom_range(1)) put_fields(msg, 1);
            do wt = 3'($urandom);
            while (wt == pffe_pkg::WT_VARINT || wt == pffe_pkg::WT_LEN_DELIM);
            put_varint(msg, {32'd0, $urandom} << 3 | wt, 0, 1'b0);
            repeat ($urandom_range(6)) msg.push_back(8'($urandom));
        end else if (sel < 79) begin
            // varint whose tenth byte still continues, as tag, value or length
            sel = $urandom_range(2);
            if (sel == 1) put_varint(msg, 64'd8, 0, 1'b0);
            if (sel == 2) begin
                put_varint(msg, ({35'd0, want_field} << 3) | pffe_pkg::WT_LEN_DELIM, 0, 1'b0);
            end
            repeat (10) msg.push_back(8'($urandom) | 8'h80);
            repeat ($urandom_range(6)) msg.push_back(8'($urandom));
        end else if (sel < 85) begin
            // declared field length runs past the end of the frame
            tail = $urandom_range(6);
            put_varint(msg, ({35'd0, want_field} << 3) | pffe_pkg::WT_LEN_DELIM, 0, 1'b0);
            put_varint(msg, 64'(tail + $urandom_range(4, 1)), 0, 1'b0);
            repeat (tail) msg.push_back(8'($urandom));
        end else if (sel < 90) begin
            // header over the limit, nothing follows
            hdr = $urandom_range(1) ? frame_cap() + 1 : ($urandom | 32'h0002_0000);
            send_header(hdr);
            return;
        end else if (sel < 93) begin
            // empty message
        end else begin
            // noise, sometimes exactly at or one past a small frame limit
            cut = $urandom_range(30, 1);
            if (frame_cap() <= 64 && $urandom_range(1)) cut = frame_cap() + $urandom_range(1);
            repeat (cut) msg.push_back(8'($urandom));
        end
        hdr = msg.size();
        send_header(hdr);
        if (hdr <= frame_cap()) send_stream(msg);
    endtask

    // ------------------------------------------------------------------
    // result sink and checker
    // ------------------------------------------------------------------

    initial begin : receiver
        int unsigned left;
        int unsigned seen_seq;
        seen_seq  = 0;
        res.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_seq != seen_seq) begin
                seen_seq  = hold_seq;
                left      = hold_cycles;
                res.ready <= 1'b0;
                while (left != 0) begin
                    @(posedge clk);
                    left--;
                end
            end else begin
                res.ready <= ($urandom_range(99) >= dst_stall_pct);
            end
        end
    end

    always @(posedge clk) begin : check_results
        pffe_pkg::t_result want;
        if (rst_n && res.valid && res.ready) begin
            if (due_results.size() == 0) begin
                $display("%0t: unexpected beat byte=%h valid=%b start=%b len=%0d done=%b st=%0d",
                         $time, res.payload_byte, res.byte_valid, res.payload_start,
                         res.payload_len, res.frame_done, res.frame_status);
                n_fail++;
            end else begin
                want = due_results.pop_front();
                if (res.payload_byte  !== want.payload_byte  ||
                    res.byte_valid    !== want.byte_valid    ||
                    res.payload_start !== want.payload_start ||
                    res.payload_len   !== want.payload_len   ||
                    res.frame_done    !== want.frame_done    ||
                    res.frame_status  !== want.frame_status) begin
                    $display("%0t: mismatch expected byte=%h valid=%b start=%b len=%0d done=%b st=%0d",
                             $time, want.payload_byte, want.byte_valid, want.payload_start,
                             want.payload_len, want.frame_done, want.frame_status);
                    $display("%0t:          actual byte=%h valid=%b start=%b len=%0d done=%b st=%0d",
                             $time, res.payload_byte, res.byte_valid, res.payload_start,
                             res.payload_len, res.frame_done, res.frame_status);
                    n_fail++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset values of the registers, hand-built frames
    task automatic test_directed_frames();
        t_bytes seq;
        src_idle_pct  = 0;
        dst_stall_pct = 0;
        // empty message, then a header far over the limit
        seq = '{8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_stream(seq);
        // field 6 of two bytes, the last value byte ends the frame
        seq = '{8'h00, 8'h00, 8'h00, 8'h04, 8'h32, 8'h02, 8'hFF, 8'h00};
        send_stream(seq);
        // wire type 3 is malformed, the next byte is drained
        seq = '{8'h00, 8'h00, 8'h00, 8'h02, 8'h0B, 8'h00};
        send_stream(seq);
        // empty target field on the last byte: start marker and frame end together
        seq = '{8'h00, 8'h00, 8'h00, 8'h02, 8'h32, 8'h00};
        send_stream(seq);
        wait_drained();
    endtask

    task automatic test_random_frames(input logic [16:0] frame_lim, input logic [15:0] pay_lim,
                                      input logic [28:0] field, input int unsigned src_pct,
                                      input int unsigned dst_pct, input int unsigned n_bytes);
        int unsigned first;
        wait_drained();
        program_limits(frame_lim, pay_lim, field);
        src_idle_pct  = src_pct;
        dst_stall_pct = dst_pct;
        first         = bytes_sent;
        while (bytes_sent - first < n_bytes) send_random_frame();
        wait_drained();
    endtask

    // receiver holds off while long target fields keep coming, so the input stalls
    task automatic test_output_stall();
        t_bytes msg;
        wait_drained();
        program_limits(17'd65536, 16'd100, 29'd6);
        src_idle_pct  = 0;
        dst_stall_pct = 0;
        put_extract_field(msg, 60);
        put_fields(msg, 2);
        hold_cycles = 300;
        hold_seq++;
        send_header(msg.size());
        send_stream(msg);
        send_header(msg.size());
        send_stream(msg);
        wait_drained();
    endtask

    // sender stops in the middle of a target field until all beats are out
    task automatic test_pause_mid_field();
        t_bytes msg;
        src_idle_pct  = 12;
        dst_stall_pct = 12;
        put_extract_field(msg, 12);
        put_fields(msg, 1);
        send_header(msg.size());
        foreach (msg[i]) begin
            if (i == 6) wait_drained();
            send_byte(msg[i]);
        end
        wait_drained();
    endtask

    initial begin
        rx.valid   <= 1'b0;
        rx.rx_byte <= 8'h00;
        cfg_we     <= 1'b0;
        cfg_idx    <= pffe_pkg::CFG_MAX_FRAME_LEN;
        cfg_data   <= '0;
        rst_n      <= 1'b0;
        lim_frame   = pffe_pkg::MAX_FRAME_LEN_RST;
        lim_payload = pffe_pkg::MAX_PAYLOAD_LEN_RST;
        want_field  = pffe_pkg::TARGET_FIELD_RST;
        clear_parser();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_frames();
        test_random_frames(17'h1FFFF, 16'hFFFF, 29'd1, 0, 0, 90);
        test_random_frames(17'd16, 16'd5, 29'h1FFF_FFFF, 84, 0, 90);
        test_random_frames(17'd65536, 16'd0, 29'd9, 0, 84, 90);
        test_random_frames(17'd0, 16'd3, 29'd6, 12, 12, 40);
        test_random_frames(17'd40, 16'd12, 29'd2, 12, 12, 90);
        test_output_stall();
        test_pause_mid_field();
        test_random_frames(17'($urandom_range(65536, 24)), 16'($urandom_range(40)),
                           29'($urandom_range(29'h1FFF_FFFF, 1)), 84, 84, 90);

        wait_drained();
        repeat (8) @(posedge clk);
        if (n_fail == 0) begin
            $display("PASS protobuf_frame_field_extractor");
        end else begin
            $display("FAIL protobuf_frame_field_extractor");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("FAIL protobuf_frame_field_extractor");
        $finish;
    end

endmodule

### files.f
rtl/pffe_pkg.sv
rtl/pffe_if.sv
rtl/pffe_parser.sv
rtl/protobuf_frame_field_extractor.sv
dv/tb.sv
